### sv/psp_pkg.sv
// Shared types and constants for the pump status poll frame checker.
// Used by psp_temp_filter and pump_status_poll_frame_checker_unit; no dependencies.
package psp_pkg;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_OPEN  = 2'd2;
  localparam logic [1:0] MODE_CLOSE = 2'd3;

  localparam logic [1:0] CMD_INQUIRE = 2'd0;
  localparam logic [1:0] CMD_OPEN    = 2'd1;
  localparam logic [1:0] CMD_CLOSE   = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [4:0] FRAME_LAST_INDEX = 5'd19;
  localparam logic [4:0] POS_STATUS       = 5'd3;
  localparam logic [4:0] POS_TEMP_HI      = 5'd5;
  localparam logic [4:0] POS_TEMP_MID     = 5'd6;
  localparam logic [4:0] POS_TEMP_LO      = 5'd7;
  localparam logic [4:0] POS_ERROR        = 5'd16;
  localparam logic [4:0] POS_CHECK        = FRAME_LAST_INDEX - 5'd1;
  localparam logic [4:0] POS_SUM_LAST     = FRAME_LAST_INDEX - 5'd2;

  localparam logic [7:0] TERMINATOR = 8'hFE;

  localparam logic [21:0] JUMP_LIMIT_RESET = 22'd3500;
  localparam logic [21:0] MIN_TEMP_RESET   = 22'd100;
  localparam logic [21:0] TEMP_MAX         = 22'd2575755;

  localparam logic [0:0] REG_JUMP_LIMIT = 1'b0;
  localparam logic [0:0] REG_MIN_TEMP   = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  pump_state;
    logic [7:0]  pump_error;
    logic [21:0] temp_hundredths;
    logic [1:0]  next_command;
  } out_word_t;

  typedef struct packed {
    logic [21:0] jump_limit;
    logic [21:0] min_running_temp;
  } cfg_regs_t;

endpackage

### sv/psp_temp_filter.sv
// Converts the held temperature bytes to hundredths and applies the jump and
// minimum-running-temperature filter. Depends on psp_pkg.
module psp_temp_filter (
  input  psp_pkg::cfg_regs_t cfg,
  input  logic [7:0]         status,
  input  logic [23:0]        temp_bytes,
  input  logic [21:0]        last_temp,
  output logic [21:0]        temp_out
);

  logic [21:0] hi_part;
  logic [21:0] mid_part;
  logic [21:0] reading;
  logic [21:0] diff;
  logic        reject;

  // Constant multiplies: b5*10000 + b6*100 + b7 always fits in 22 bits.
  assign hi_part  = 22'(temp_bytes[23:16]) * 22'd10000;
  assign mid_part = 22'(temp_bytes[15:8]) * 22'd100;
  assign reading  = hi_part + mid_part + 22'(temp_bytes[7:0]);

  assign diff = (reading > last_temp) ? (reading - last_temp) : (last_temp - reading);

  assign reject = (diff > cfg.jump_limit) ||
                  ((status != 8'd0) && (reading < cfg.min_running_temp));

  assign temp_out = reject ? last_temp : reading;

endmodule

### sv/pump_status_poll_frame_checker_unit.sv
// A word is captured in the input register and processed from there; a poll tick's
// result is registered in the output register. Throughput: one word per cycle while
// no tick is stalled, set by the input register and the output register.
// A tick that meets an unaccepted result waits in the input register and stalls the
// input until out_ready is high. Reset (rst_n low, synchronous) restores the default
// limits, clears the frame and held values and sets "no command yet".
// Top level of the pump status poll frame checker. Depends on psp_pkg, psp_temp_filter.
module pump_status_poll_frame_checker_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psp_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output psp_pkg::out_word_t  out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers.
  psp_pkg::cfg_regs_t cfg_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == psp_pkg::REG_MIN_TEMP) ? 32'(cfg_r.min_running_temp)
                                                      : 32'(cfg_r.jump_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_limit       <= psp_pkg::JUMP_LIMIT_RESET;
      cfg_r.min_running_temp <= psp_pkg::MIN_TEMP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == psp_pkg::REG_MIN_TEMP) begin
        cfg_r.min_running_temp <= pwdata[21:0];
      end else begin
        cfg_r.jump_limit <= pwdata[21:0];
      end
    end
  end

  // Input register.
  logic              s1_valid_r;
  psp_pkg::in_word_t s1_word_r;
  logic              is_tick;
  logic              advance;

  // Output register.
  logic               out_valid_r;
  psp_pkg::out_word_t out_word_r;
  psp_pkg::out_word_t result;

  assign is_tick  = (s1_word_r.mode == psp_pkg::MODE_TICK);
  assign advance  = s1_valid_r && (!is_tick || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Frame and poll state.
  logic [4:0]  byte_count_r, byte_count_nxt;
  logic        frame_closed_r, frame_closed_nxt;
  logic [6:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  cap_status_r, cap_status_nxt;
  logic [7:0]  cap_error_r, cap_error_nxt;
  logic [23:0] cap_temp_r, cap_temp_nxt;
  logic [7:0]  cap_check_r, cap_check_nxt;
  logic [7:0]  held_status_r, held_status_nxt;
  logic [7:0]  held_error_r, held_error_nxt;
  logic [23:0] held_temp_r, held_temp_nxt;
  logic [21:0] last_temp_r, last_temp_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic        open_pend_r, open_pend_nxt;
  logic        close_pend_r, close_pend_nxt;
  logic        reply_seen_r, reply_seen_nxt;

  logic        frame_good;
  logic [21:0] filtered_temp;
  logic [7:0]  rx;

  assign rx = s1_word_r.rx_byte;

  assign frame_good = frame_closed_r && (byte_count_r == psp_pkg::FRAME_LAST_INDEX) &&
                      ({1'b0, running_sum_r} == cap_check_r);

  psp_temp_filter u_temp_filter (
    .cfg        (cfg_r),
    .status     (held_status_nxt),
    .temp_bytes (held_temp_nxt),
    .last_temp  (last_temp_r),
    .temp_out   (filtered_temp)
  );

  always_comb begin
    held_status_nxt = held_status_r;
    held_error_nxt  = held_error_r;
    held_temp_nxt   = held_temp_r;
    // The frame check only applies to a tick that follows an inquiry.
    if (is_tick && (cmd_r == psp_pkg::CMD_INQUIRE)) begin
      if (frame_good) begin
        held_status_nxt = cap_status_r;
        held_error_nxt  = cap_error_r;
        held_temp_nxt   = cap_temp_r;
      end else if (byte_count_r == 5'd0) begin
        held_status_nxt = 8'd0;
        held_error_nxt  = 8'd0;
        held_temp_nxt   = 24'd0;
      end
    end
  end

  always_comb begin
    byte_count_nxt   = byte_count_r;
    frame_closed_nxt = frame_closed_r;
    running_sum_nxt  = running_sum_r;
    cap_status_nxt   = cap_status_r;
    cap_error_nxt    = cap_error_r;
    cap_temp_nxt     = cap_temp_r;
    cap_check_nxt    = cap_check_r;
    last_temp_nxt    = last_temp_r;
    cmd_nxt          = cmd_r;
    open_pend_nxt    = open_pend_r;
    close_pend_nxt   = close_pend_r;
    reply_seen_nxt   = reply_seen_r;

    case (s1_word_r.mode)
      psp_pkg::MODE_BYTE: begin
        reply_seen_nxt = 1'b1;
        if (!frame_closed_r) begin
          if ((byte_count_r >= 5'd1) && (byte_count_r <= psp_pkg::POS_SUM_LAST)) begin
            running_sum_nxt = running_sum_r + rx[6:0];
          end
          case (byte_count_r)
            psp_pkg::POS_STATUS:   cap_status_nxt      = rx;
            psp_pkg::POS_ERROR:    cap_error_nxt       = rx;
            psp_pkg::POS_TEMP_HI:  cap_temp_nxt[23:16] = rx;
            psp_pkg::POS_TEMP_MID: cap_temp_nxt[15:8]  = rx;
            psp_pkg::POS_TEMP_LO:  cap_temp_nxt[7:0]   = rx;
            psp_pkg::POS_CHECK:    cap_check_nxt       = rx;
            default: ;
          endcase
          if ((rx != psp_pkg::TERMINATOR) && (byte_count_r < psp_pkg::FRAME_LAST_INDEX)) begin
            byte_count_nxt = byte_count_r + 5'd1;
          end else begin
            frame_closed_nxt = 1'b1;
          end
        end
      end
      psp_pkg::MODE_OPEN: begin
        open_pend_nxt = 1'b1;
      end
      psp_pkg::MODE_CLOSE: begin
        close_pend_nxt = 1'b1;
      end
      default: begin
        // Poll tick.
        case (cmd_r)
          psp_pkg::CMD_INQUIRE: last_temp_nxt  = filtered_temp;
          psp_pkg::CMD_OPEN:    open_pend_nxt  = reply_seen_r;
          psp_pkg::CMD_CLOSE:   close_pend_nxt = reply_seen_r;
          default: ;
        endcase
        if (open_pend_nxt) begin
          cmd_nxt = psp_pkg::CMD_OPEN;
        end else if (close_pend_nxt) begin
          cmd_nxt = psp_pkg::CMD_CLOSE;
        end else begin
          cmd_nxt = psp_pkg::CMD_INQUIRE;
        end
        byte_count_nxt   = 5'd0;
        frame_closed_nxt = 1'b0;
        running_sum_nxt  = 7'd0;
        reply_seen_nxt   = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.frame_ok        = (cmd_r == psp_pkg::CMD_INQUIRE) && frame_good;
    result.pump_state      = held_status_nxt;
    result.pump_error      = held_error_nxt;
    result.temp_hundredths = last_temp_nxt;
    result.next_command    = cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      byte_count_r   <= 5'd0;
      frame_closed_r <= 1'b0;
      running_sum_r  <= 7'd0;
      cap_status_r   <= 8'd0;
      cap_error_r    <= 8'd0;
      cap_temp_r     <= 24'd0;
      cap_check_r    <= 8'd0;
      held_status_r  <= 8'd0;
      held_error_r   <= 8'd0;
      held_temp_r    <= 24'd0;
      last_temp_r    <= 22'd0;
      cmd_r          <= psp_pkg::CMD_NONE;
      open_pend_r    <= 1'b0;
      close_pend_r   <= 1'b0;
      reply_seen_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance && is_tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        byte_count_r   <= byte_count_nxt;
        frame_closed_r <= frame_closed_nxt;
        running_sum_r  <= running_sum_nxt;
        cap_status_r   <= cap_status_nxt;
        cap_error_r    <= cap_error_nxt;
        cap_temp_r     <= cap_temp_nxt;
        cap_check_r    <= cap_check_nxt;
        held_status_r  <= held_status_nxt;
        held_error_r   <= held_error_nxt;
        held_temp_r    <= held_temp_nxt;
        last_temp_r    <= last_temp_nxt;
        cmd_r          <= cmd_nxt;
        open_pend_r    <= open_pend_nxt;
        close_pend_r   <= close_pend_nxt;
        reply_seen_r   <= reply_seen_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_word;
    end
    if (advance && is_tick) begin
      out_word_r <= result;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= psp_pkg::FRAME_LAST_INDEX)
    else $error("frame position ran past the last index");

  a_cmd_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> cmd_r != psp_pkg::CMD_NONE)
    else $error("no command chosen after a poll tick");

  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && is_tick))
    else $error("result appeared without a poll tick");

  a_frame_reset_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> byte_count_r == 5'd0 && !frame_closed_r && !reply_seen_r)
    else $error("frame not restarted after a poll tick");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.temp_hundredths <= psp_pkg::TEMP_MAX)
    else $error("temperature outside its range");

endmodule
